[hdl/assert_macros.svh]
// Assertion macros shared by the serial link shift port RTL.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/slsp_pkg.sv]
// Package for the serial link shift port: operation codes, register offsets,
// item and result structures and fixed constants. No dependencies.
`default_nettype none

package slsp_pkg;

   // Clock cycles per machine cycle of the emulated device.
   localparam int CLOCKS_PER_MCYCLE = 4;

   localparam int ACC_W    = 20;
   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 4;

   localparam logic [ACC_W-1:0]    ACC_MAX        = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd512;
   localparam logic [7:0]          UNLINKED_BYTE  = 8'hFF;
   localparam logic [COUNT_W-1:0]  SHIFT_COUNT    = 4'd8;
   localparam int                  SC_START_BIT   = 7;
   localparam int                  SC_CLOCK_BIT   = 0;

   // Operation carried by one item.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Register offsets of the serial port.
   localparam logic [1:0] REG_SB = 2'd0;
   localparam logic [1:0] REG_SC = 2'd1;

   // Configuration register indexes.
   localparam logic CSR_PERIOD = 1'b0;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] machine_cycles;
      logic       link_byte_arrived;
      logic       link_connected;
      logic [7:0] link_rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       send_valid;
      logic [7:0] send_byte;
      logic       serial_irq;
      logic       bad_address;
   } result_type;

endpackage

`default_nettype wire

[hdl/slsp_core.sv]
// Serial port state and its combinational update for one item, registered on step.
// Depends on slsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slsp_core
   import slsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [PERIOD_W-1:0] period,
   input  logic                step,
   input  item_type            item,
   output result_type          result
);

   logic [7:0]         data_ff, data_in;
   logic [7:0]         control_ff, control_in;
   logic               master_ff, master_in;
   logic [7:0]         sent_ff, sent_in;
   logic [7:0]         recv_ff, recv_in;
   logic [15:0]        shifter_ff, shifter_in;
   logic [COUNT_W-1:0] shifts_ff, shifts_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic [ACC_W:0]     acc_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic               shift_due;
   logic [ACC_W-1:0]   acc_after;
   op_type             op;

   assign op = op_type'(item.op);

   // Accumulate the tick's clocks, saturate, and take one period off when due.
   assign acc_sum   = {1'b0, acc_ff}
                    + ((ACC_W+1)'(item.machine_cycles) * (ACC_W+1)'(CLOCKS_PER_MCYCLE));
   assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign shift_due = acc_sat >= ACC_W'(period);
   assign acc_after = shift_due ? acc_sat - ACC_W'(period) : acc_sat;

   // Next state and result for the item in hand.
   always_comb begin
      data_in    = data_ff;
      control_in = control_ff;
      master_in  = master_ff;
      sent_in    = sent_ff;
      recv_in    = recv_ff;
      shifter_in = shifter_ff;
      shifts_in  = shifts_ff;
      acc_in     = acc_ff;
      result     = '0;

      unique case (op)
         OP_WRITE: begin
            unique case (item.reg_index)
               REG_SB: begin
                  data_in = item.write_data;
               end
               REG_SC: begin
                  control_in = item.write_data;
                  if (item.write_data[SC_START_BIT] && item.write_data[SC_CLOCK_BIT]) begin
                     master_in = 1'b1;
                     sent_in   = data_ff;
                     if (item.link_connected) begin
                        result.send_valid = 1'b1;
                        result.send_byte  = data_ff;
                     end else begin
                        recv_in = UNLINKED_BYTE;
                     end
                  end
               end
               default: begin
                  result.bad_address = 1'b1;
               end
            endcase
         end
         OP_READ: begin
            unique case (item.reg_index)
               REG_SB:  result.read_data   = data_ff;
               REG_SC:  result.read_data   = control_ff;
               default: result.bad_address = 1'b1;
            endcase
         end
         OP_TICK: begin
            acc_in = acc_after;
            // A byte arrival loads the shifter and restarts the transfer.
            if (item.link_byte_arrived) begin
               if (master_ff) begin
                  recv_in = item.link_connected ? item.link_rx_byte : UNLINKED_BYTE;
               end else begin
                  sent_in = data_ff;
                  if (item.link_connected) begin
                     recv_in           = item.link_rx_byte;
                     result.send_valid = 1'b1;
                     result.send_byte  = data_ff;
                  end else begin
                     recv_in = UNLINKED_BYTE;
                  end
               end
               shifter_in = {sent_in, recv_in};
               shifts_in  = SHIFT_COUNT;
            end
            // At most one shift per tick; the last one ends the transfer.
            if (shift_due && (shifts_in != '0)) begin
               shifter_in = {shifter_in[14:0], 1'b0};
               shifts_in  = shifts_in - COUNT_W'(1);
               data_in    = shifter_in[15:8];
               if (shifts_in == '0) begin
                  result.serial_irq        = 1'b1;
                  control_in[SC_START_BIT] = 1'b0;
                  master_in                = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff    <= '0;
         control_ff <= '0;
         master_ff  <= 1'b0;
         sent_ff    <= '0;
         recv_ff    <= '0;
         shifter_ff <= '0;
         shifts_ff  <= '0;
         acc_ff     <= '0;
      end else if (step) begin
         data_ff    <= data_in;
         control_ff <= control_in;
         master_ff  <= master_in;
         sent_ff    <= sent_in;
         recv_ff    <= recv_in;
         shifter_ff <= shifter_in;
         shifts_ff  <= shifts_in;
         acc_ff     <= acc_in;
      end
   end

   `ASSERT_SAME(a_shift_count_range, 1'b1, shifts_ff <= SHIFT_COUNT)
   `ASSERT_SAME(a_irq_not_with_send, step, !(result.serial_irq && result.send_valid))
   `ASSERT_SAME(a_bad_addr_quiet, step && result.bad_address,
                result.read_data == '0 && !result.send_valid && !result.serial_irq)

endmodule

`default_nettype wire

[hdl/serial_link_shift_port_core.sv]
// Top level of the serial link shift port: handshakes, input and result
// registers, configuration port. Depends on slsp_pkg, slsp_core, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  op, reg_index, write_data, machine_cycles,
//                                           link_byte_arrived, link_connected, link_rx_byte
// rsp_      out        rsp_valid/rsp_ready  read_data, send_valid, send_byte,
//                                           serial_irq, bad_address
// csr_      in         APB write/read       clocks_per_shift at byte address 0
//
// One item per cycle is sustained while results are taken. An item is registered on
// acceptance and processed against the port state when the result register can take
// its result; processing also loads the result register, and that single update pass
// sets the rate. A full result register that is not taken stalls processing, and the
// input register then holds its item while req_ready drops.
// Synchronous reset clears the port state and sets clocks_per_shift to 512.

module serial_link_shift_port_core
   import slsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_machine_cycles,
   input  logic        req_link_byte_arrived,
   input  logic        req_link_connected,
   input  logic [7:0]  req_link_rx_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_send_valid,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_serial_irq,
   output logic        rsp_bad_address,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                item_valid_ff, item_valid_in;
   item_type            item_ff;
   logic                res_valid_ff, res_valid_in;
   result_type          res_ff;
   result_type          res_comb;
   logic [PERIOD_W-1:0] period_ff;
   logic                process;
   logic                req_take;
   logic                csr_write;
   logic                csr_hit;

   // Process when an item waits and the result register can take its result.
   // No item is taken while reset is held.
   assign process   = item_valid_ff && (!res_valid_ff || rsp_ready);
   assign req_ready = !reset && (!item_valid_ff || process);
   assign req_take  = req_valid && req_ready;

   assign item_valid_in = req_take || (item_valid_ff && !process);
   assign res_valid_in  = process || (res_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_take) begin
         item_ff <= '{op:                req_op,
                      reg_index:         req_reg_index,
                      write_data:        req_write_data,
                      machine_cycles:    req_machine_cycles,
                      link_byte_arrived: req_link_byte_arrived,
                      link_connected:    req_link_connected,
                      link_rx_byte:      req_link_rx_byte};
      end
   end

   slsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .period (period_ff),
      .step   (process),
      .item   (item_ff),
      .result (res_comb)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
      if (process) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_read_data   = res_ff.read_data;
   assign rsp_send_valid  = res_ff.send_valid;
   assign rsp_send_byte   = res_ff.send_byte;
   assign rsp_serial_irq  = res_ff.serial_irq;
   assign rsp_bad_address = res_ff.bad_address;

   // Configuration register, written in the APB access phase.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_PERIOD);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write && csr_hit) begin
         period_ff <= csr_pwdata[PERIOD_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {{(32-PERIOD_W){1'b0}}, period_ff} : '0;

   `ASSERT_NEXT(a_item_kept_on_stall, item_valid_ff && !process, item_valid_ff)
   `ASSERT_NEXT(a_result_loaded, process, res_valid_ff)
   `ASSERT_SAME(a_no_take_when_full, item_valid_ff && !process, !req_ready)

endmodule

`default_nettype wire
